// File: rtl/core/hid_pkg.sv
// ----------------------------------------------------------------------------
// hid_pkg
// Shared widths, microcode field codes, control word layout and the
// microprogram of the horizontal impact detector.
// ----------------------------------------------------------------------------
package hid_pkg;

  // Field widths of one sample and of one result
  localparam int ACCEL_W = 16;
  localparam int QUAT_W  = 16;
  localparam int THR_W   = 15;
  localparam int MAG_W   = 32;

  localparam logic [THR_W-1:0] THR_RESET = 15'd2511;

  // Fraction bits dropped from a Q4.28 matrix entry and from a rotated axis
  localparam int FRAC_W = 14;

  // Datapath widths: matrix entries fit 20 bits, world axes 22 bits
  localparam int ROW_W  = 20;
  localparam int AXIS_W = 22;
  localparam int OPD_W  = 22;
  localparam int PROD_W = 2 * OPD_W;
  localparam int ACC_W  = 46;

  // Microprogram size
  localparam int STEP_W    = 5;
  localparam int NUM_STEPS = 29;

  // One sample on tdata, accel_x in the lowest bits
  typedef struct packed {
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [ACCEL_W-1:0] accel_z;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_x;
  } in_data_t;

  localparam int IN_DATA_W = $bits(in_data_t);

  // Multiplier operand select
  typedef enum logic [3:0] {
    OPD_QW,
    OPD_QX,
    OPD_QY,
    OPD_QZ,
    OPD_AX,
    OPD_AY,
    OPD_AZ,
    OPD_R0,
    OPD_R1,
    OPD_R2,
    OPD_WX,
    OPD_WY,
    OPD_TH
  } opd_sel_e;

  // Accumulator operation on the registered product
  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  // Writeback target of the accumulator
  typedef enum logic [2:0] {
    WB_NONE,
    WB_R0,
    WB_R1,
    WB_R2,
    WB_WX,
    WB_WY,
    WB_MAG
  } wb_dst_e;

  // Conditional jump: stay on the current step while the condition holds
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_e;

  // One control word
  typedef struct packed {
    opd_sel_e sel_a;
    opd_sel_e sel_b;
    acc_op_e  acc_op;
    wb_dst_e  wb_dst;
    logic     wb_half;    // doubled matrix entry: drop one bit less
    hold_e    hold;
    logic     take_item;  // idle step: sample port is open
    logic     finish;     // last step: update flags, issue result, wrap
  } uword_t;

  // Status from the datapath to the top level
  typedef struct packed {
    logic             above;
    logic [MAG_W-1:0] mag;
  } dp_status_t;

  function automatic uword_t mk_word(input opd_sel_e a, input opd_sel_e b,
                                     input acc_op_e op, input wb_dst_e dst,
                                     input logic half, input hold_e hold,
                                     input logic take, input logic fin);
    uword_t w;
    w.sel_a     = a;
    w.sel_b     = b;
    w.acc_op    = op;
    w.wb_dst    = dst;
    w.wb_half   = half;
    w.hold      = hold;
    w.take_item = take;
    w.finish    = fin;
    return w;
  endfunction

  // Microprogram. A product issued at step k is accumulated at step k+1;
  // a writeback at step k sees the accumulator as left by step k-1.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      // idle, wait for a sample
      5'd0:  w = mk_word(OPD_QW, OPD_QW, ACC_NOP,  WB_NONE, 1'b0, HOLD_IN,   1'b1, 1'b0);
      // row 0: R00 = aa + bb - cc - dd
      5'd1:  w = mk_word(OPD_QW, OPD_QW, ACC_NOP,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd2:  w = mk_word(OPD_QX, OPD_QX, ACC_LOAD, WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd3:  w = mk_word(OPD_QY, OPD_QY, ACC_ADD,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd4:  w = mk_word(OPD_QZ, OPD_QZ, ACC_SUB,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      // R01 = 2(bc - ad)
      5'd5:  w = mk_word(OPD_QX, OPD_QY, ACC_SUB,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd6:  w = mk_word(OPD_QW, OPD_QZ, ACC_LOAD, WB_R0,   1'b0, HOLD_NONE, 1'b0, 1'b0);
      // R02 = 2(ac + bd)
      5'd7:  w = mk_word(OPD_QW, OPD_QY, ACC_SUB,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd8:  w = mk_word(OPD_QX, OPD_QZ, ACC_LOAD, WB_R1,   1'b1, HOLD_NONE, 1'b0, 1'b0);
      // wx = R0 . a
      5'd9:  w = mk_word(OPD_R0, OPD_AX, ACC_ADD,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd10: w = mk_word(OPD_R1, OPD_AY, ACC_LOAD, WB_R2,   1'b1, HOLD_NONE, 1'b0, 1'b0);
      5'd11: w = mk_word(OPD_R2, OPD_AZ, ACC_ADD,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      // row 1: R10 = 2(bc + ad)
      5'd12: w = mk_word(OPD_QX, OPD_QY, ACC_ADD,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd13: w = mk_word(OPD_QW, OPD_QZ, ACC_LOAD, WB_WX,   1'b0, HOLD_NONE, 1'b0, 1'b0);
      // R11 = aa - bb + cc - dd
      5'd14: w = mk_word(OPD_QW, OPD_QW, ACC_ADD,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd15: w = mk_word(OPD_QX, OPD_QX, ACC_LOAD, WB_R0,   1'b1, HOLD_NONE, 1'b0, 1'b0);
      5'd16: w = mk_word(OPD_QY, OPD_QY, ACC_SUB,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd17: w = mk_word(OPD_QZ, OPD_QZ, ACC_ADD,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      // R12 = 2(cd - ab)
      5'd18: w = mk_word(OPD_QY, OPD_QZ, ACC_SUB,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd19: w = mk_word(OPD_QW, OPD_QX, ACC_LOAD, WB_R1,   1'b0, HOLD_NONE, 1'b0, 1'b0);
      // wy = R1 . a
      5'd20: w = mk_word(OPD_R0, OPD_AX, ACC_SUB,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd21: w = mk_word(OPD_R1, OPD_AY, ACC_LOAD, WB_R2,   1'b1, HOLD_NONE, 1'b0, 1'b0);
      5'd22: w = mk_word(OPD_R2, OPD_AZ, ACC_ADD,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      // squared magnitude, then compare against threshold squared
      5'd23: w = mk_word(OPD_WX, OPD_WX, ACC_ADD,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd24: w = mk_word(OPD_WX, OPD_WX, ACC_LOAD, WB_WY,   1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd25: w = mk_word(OPD_WY, OPD_WY, ACC_NOP,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd26: w = mk_word(OPD_TH, OPD_TH, ACC_ADD,  WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b0);
      5'd27: w = mk_word(OPD_TH, OPD_TH, ACC_SUB,  WB_MAG,  1'b0, HOLD_NONE, 1'b0, 1'b0);
      // issue result once the output register is free
      5'd28: w = mk_word(OPD_TH, OPD_TH, ACC_NOP,  WB_NONE, 1'b0, HOLD_OUT,  1'b0, 1'b1);
      default: w = mk_word(OPD_QW, OPD_QW, ACC_NOP, WB_NONE, 1'b0, HOLD_NONE, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/hid_sequencer.sv
// ----------------------------------------------------------------------------
// hid_sequencer
// Step counter and microcode lookup; holds on a step while its jump
// condition is true, wraps to the idle step after the last one.
// ----------------------------------------------------------------------------
module hid_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_stall_i,
  output hid_pkg::uword_t ctrl_o
);

  logic [hid_pkg::STEP_W-1:0] step_q, step_d;
  logic                       hold;

  // Fetch the control word of the current step
  assign ctrl_o = hid_pkg::ucode(step_q);

  // Evaluate the jump condition
  always_comb begin
    unique case (ctrl_o.hold)
      hid_pkg::HOLD_IN:  hold = ~in_valid_i;
      hid_pkg::HOLD_OUT: hold = out_stall_i;
      default:           hold = 1'b0;
    endcase
  end

  // Advance, hold or wrap
  always_comb begin
    if (hold) begin
      step_d = step_q;
    end else if (ctrl_o.finish) begin
      step_d = '0;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: rtl/core/hid_datapath.sv
// ----------------------------------------------------------------------------
// hid_datapath
// Operand registers, one shared signed multiplier with a product register,
// an accumulator and the writeback path, all steered by the control word.
// ----------------------------------------------------------------------------
module hid_datapath (
  input  logic                            clk_i,
  input  hid_pkg::uword_t                 ctrl_i,
  input  logic                            load_i,
  input  hid_pkg::in_data_t               item_i,
  input  logic [hid_pkg::THR_W-1:0]       thr_i,
  output hid_pkg::dp_status_t             status_o
);

  // Sample operands
  logic signed [hid_pkg::ACCEL_W-1:0] ax_q, ay_q, az_q;
  logic signed [hid_pkg::QUAT_W-1:0]  qw_q, qx_q, qy_q, qz_q;

  // Intermediate results
  logic signed [hid_pkg::ROW_W-1:0]   r0_q, r1_q, r2_q;
  logic signed [hid_pkg::AXIS_W-1:0]  wx_q, wy_q;
  logic [hid_pkg::MAG_W-1:0]          mag_q;

  logic signed [hid_pkg::OPD_W-1:0]   opa, opb;
  logic signed [hid_pkg::PROD_W-1:0]  prod_q;
  logic signed [hid_pkg::ACC_W-1:0]   acc_q, acc_d, prod_ext, acc_shr;

  function automatic logic signed [hid_pkg::OPD_W-1:0] pick(
    input hid_pkg::opd_sel_e                sel,
    input logic signed [hid_pkg::ACCEL_W-1:0] ax,
    input logic signed [hid_pkg::ACCEL_W-1:0] ay,
    input logic signed [hid_pkg::ACCEL_W-1:0] az,
    input logic signed [hid_pkg::QUAT_W-1:0]  qw,
    input logic signed [hid_pkg::QUAT_W-1:0]  qx,
    input logic signed [hid_pkg::QUAT_W-1:0]  qy,
    input logic signed [hid_pkg::QUAT_W-1:0]  qz,
    input logic signed [hid_pkg::ROW_W-1:0]   r0,
    input logic signed [hid_pkg::ROW_W-1:0]   r1,
    input logic signed [hid_pkg::ROW_W-1:0]   r2,
    input logic signed [hid_pkg::AXIS_W-1:0]  wx,
    input logic signed [hid_pkg::AXIS_W-1:0]  wy,
    input logic [hid_pkg::THR_W-1:0]          th);
    logic signed [hid_pkg::OPD_W-1:0] v;
    unique case (sel)
      hid_pkg::OPD_QW: v = hid_pkg::OPD_W'(qw);
      hid_pkg::OPD_QX: v = hid_pkg::OPD_W'(qx);
      hid_pkg::OPD_QY: v = hid_pkg::OPD_W'(qy);
      hid_pkg::OPD_QZ: v = hid_pkg::OPD_W'(qz);
      hid_pkg::OPD_AX: v = hid_pkg::OPD_W'(ax);
      hid_pkg::OPD_AY: v = hid_pkg::OPD_W'(ay);
      hid_pkg::OPD_AZ: v = hid_pkg::OPD_W'(az);
      hid_pkg::OPD_R0: v = hid_pkg::OPD_W'(r0);
      hid_pkg::OPD_R1: v = hid_pkg::OPD_W'(r1);
      hid_pkg::OPD_R2: v = hid_pkg::OPD_W'(r2);
      hid_pkg::OPD_WX: v = hid_pkg::OPD_W'(wx);
      hid_pkg::OPD_WY: v = hid_pkg::OPD_W'(wy);
      hid_pkg::OPD_TH: v = {{(hid_pkg::OPD_W - hid_pkg::THR_W){1'b0}}, th};
      default:         v = '0;
    endcase
    return v;
  endfunction

  // Select multiplier operands
  assign opa = pick(ctrl_i.sel_a, ax_q, ay_q, az_q, qw_q, qx_q, qy_q, qz_q,
                    r0_q, r1_q, r2_q, wx_q, wy_q, thr_i);
  assign opb = pick(ctrl_i.sel_b, ax_q, ay_q, az_q, qw_q, qx_q, qy_q, qz_q,
                    r0_q, r1_q, r2_q, wx_q, wy_q, thr_i);

  // Accumulate the product issued on the previous step
  assign prod_ext = hid_pkg::ACC_W'(prod_q);

  always_comb begin
    case (ctrl_i.acc_op)
      hid_pkg::ACC_LOAD: acc_d = prod_ext;
      hid_pkg::ACC_ADD:  acc_d = acc_q + prod_ext;
      hid_pkg::ACC_SUB:  acc_d = acc_q - prod_ext;
      default:           acc_d = acc_q;
    endcase
  end

  // Floor the accumulator by dropping 14 fraction bits, 13 for doubled entries
  assign acc_shr = ctrl_i.wb_half ? (acc_q >>> (hid_pkg::FRAC_W - 1))
                                  : (acc_q >>> hid_pkg::FRAC_W);

  // Load sample operands
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ax_q <= item_i.accel_x;
      ay_q <= item_i.accel_y;
      az_q <= item_i.accel_z;
      qw_q <= item_i.quat_w;
      qx_q <= item_i.quat_x;
      qy_q <= item_i.quat_y;
      qz_q <= item_i.quat_z;
    end
  end

  // Multiply and accumulate
  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    acc_q  <= acc_d;
  end

  // Write back intermediate results
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.wb_dst)
      hid_pkg::WB_R0: r0_q <= acc_shr[hid_pkg::ROW_W-1:0];
      hid_pkg::WB_R1: r1_q <= acc_shr[hid_pkg::ROW_W-1:0];
      hid_pkg::WB_R2: r2_q <= acc_shr[hid_pkg::ROW_W-1:0];
      hid_pkg::WB_WX: wx_q <= acc_shr[hid_pkg::AXIS_W-1:0];
      hid_pkg::WB_WY: wy_q <= acc_shr[hid_pkg::AXIS_W-1:0];
      hid_pkg::WB_MAG: begin
        // saturate the non-negative sum of squares to 32 bits
        if (|acc_q[hid_pkg::ACC_W-1:hid_pkg::MAG_W]) begin
          mag_q <= '1;
        end else begin
          mag_q <= acc_q[hid_pkg::MAG_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Accumulator holds magnitude minus threshold squared on the last step
  assign status_o.above = ~acc_q[hid_pkg::ACC_W-1] & (|acc_q);
  assign status_o.mag   = mag_q;

endmodule

// File: rtl/core/horizontal_impact_detector.sv
// ----------------------------------------------------------------------------
// horizontal_impact_detector
// Rotates body acceleration to the world frame, squares the horizontal part
// and tracks the impact recovery flag against a programmable threshold.
// ----------------------------------------------------------------------------
// A sample is taken only in the idle step of a 29-step microprogram, so the
// block takes no new sample before it is through with the previous one. The
// length of the program is set by the single 22x22 multiplier through which
// all quaternion products, the two matrix-row dot products and the squares
// pass one per cycle. The result sits in an output register, so a new sample
// may be taken while it waits; if the previous result is still waiting when
// the next one is ready, the program holds on its last step.
// The threshold may be written at any time the block is idle.
module horizontal_impact_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z
  input  logic [hid_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // is_armed, recovery_reset
  input  logic [1:0]                          s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // horizontal_mag_sq
  output logic [hid_pkg::MAG_W-1:0]           m_axis_tdata,
  // in_recovery
  output logic [0:0]                          m_axis_tuser,
  // threshold write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hid_pkg::THR_W-1:0]           cfg_data_i
);

  hid_pkg::uword_t     ctrl;
  hid_pkg::dp_status_t status;

  logic                      item_take, out_stall, finish_fire;
  logic [hid_pkg::THR_W-1:0] thr_q;
  logic                      armed_q, rreset_q;
  logic                      rec_q, rec_d, spike_done_q, spike_done_d;
  logic                      m_valid_q;
  logic [hid_pkg::MAG_W-1:0] m_data_q;
  logic                      m_rec_q;

  assign s_axis_tready = ctrl.take_item;
  assign item_take     = s_axis_tvalid & ctrl.take_item;
  assign out_stall     = m_valid_q & ~m_axis_tready;
  assign finish_fire   = ctrl.finish & ~out_stall;

  hid_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_stall_i (out_stall),
    .ctrl_o      (ctrl)
  );

  hid_datapath u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .load_i   (item_take),
    .item_i   (hid_pkg::in_data_t'(s_axis_tdata)),
    .thr_i    (thr_q),
    .status_o (status)
  );

  // Threshold register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= hid_pkg::THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Latch the sample flags
  always_ff @(posedge clk_i) begin
    if (item_take) begin
      armed_q  <= s_axis_tuser[0];
      rreset_q <= s_axis_tuser[1];
    end
  end

  // Recovery flag update: re-arm first, then detect or clear
  always_comb begin
    rec_d        = rec_q;
    spike_done_d = spike_done_q;
    if (armed_q) begin
      spike_done_d = spike_done_q | ~status.above;
      if (!rec_q && spike_done_d) begin
        if (status.above) begin
          rec_d        = 1'b1;
          spike_done_d = 1'b0;
        end
      end else if (rec_q && rreset_q) begin
        rec_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q        <= 1'b0;
      spike_done_q <= 1'b1;
    end else if (finish_fire) begin
      rec_q        <= rec_d;
      spike_done_q <= spike_done_d;
    end
  end

  // Output register: load on finish, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (finish_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      m_data_q <= status.mag;
      m_rec_q  <= rec_d;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_rec_q;

endmodule

// File: rtl/core/hid_checker.sv
// ----------------------------------------------------------------------------
// hid_checker
// Port-level checks of the horizontal impact detector, bound to the top.
// ----------------------------------------------------------------------------
module hid_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hid_pkg::MAG_W-1:0]     m_axis_tdata,
  input logic [0:0]                    m_axis_tuser
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q, pend_d;
  logic       prev_rec_q;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  // Track samples taken whose result is not yet out
  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      prev_rec_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_xfer) begin
        prev_rec_q <= m_axis_tuser[0];
      end
    end
  end

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  // Emit no result without a sample behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pend_q != 2'd0)
    else $error("result without a pending sample");

  // At most one sample in work plus one result waiting
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many samples in flight");

  // Entering recovery needs a magnitude above the threshold, so never zero
  a_rise_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && m_axis_tuser[0] && !prev_rec_q |-> m_axis_tdata != '0)
    else $error("recovery entered on zero magnitude");

endmodule

bind horizontal_impact_detector hid_checker u_hid_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the horizontal impact detector. Samples go in
// through a queue-fed driver, results come back through a monitor that holds
// its own fixed-point model of the rotation, the squared horizontal magnitude
// and the recovery flags, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RANDOM_PER_PHASE = 242;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned HOLD_AFTER = 200;

  // Quaternion one in Q2.14 and the cosine of 45 degrees
  localparam int Q_ONE = 16384;
  localparam int Q_C45 = 11585;

  typedef struct packed {
    hid_pkg::in_data_t data;
    logic              armed;
    logic              rreset;
  } sample_t;

  typedef struct packed {
    logic                     in_recovery;
    logic [hid_pkg::MAG_W-1:0] mag_sq;
  } result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [hid_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                     s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [hid_pkg::MAG_W-1:0]      m_axis_tdata;
  logic [0:0]                     m_axis_tuser;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [hid_pkg::THR_W-1:0]      cfg_data_i = '0;

  sample_t pending_samples[$];
  result_t expected_results[$];

  // Model state: threshold, recovery flag, spike-over flag
  logic [hid_pkg::THR_W-1:0] thr_model = hid_pkg::THR_RESET;
  logic                      recov_model = 1'b0;
  logic                      spike_over = 1'b1;

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  logic        no_gaps = 1'b0;

  horizontal_impact_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One world axis: floored matrix row dotted with the body vector, floored
  // again and clamped to the signed 32-bit range
  function automatic longint rotate_axis(longint r0, longint r1, longint r2,
                                         longint ax, longint ay, longint az);
    longint acc;
    acc = (r0 >>> 14) * ax + (r1 >>> 14) * ay + (r2 >>> 14) * az;
    acc = acc >>> 14;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc;
  endfunction

  // Exact squared horizontal magnitude of one sample
  function automatic longint unsigned horiz_mag_sq(hid_pkg::in_data_t d);
    longint a, b, c, q, ax, ay, az, wx, wy;
    longint r00, r01, r02, r10, r11, r12;
    a = d.quat_w;
    b = d.quat_x;
    c = d.quat_y;
    q = d.quat_z;
    ax = d.accel_x;
    ay = d.accel_y;
    az = d.accel_z;
    r00 = a * a + b * b - c * c - q * q;
    r01 = 2 * (b * c - a * q);
    r02 = 2 * (a * c + b * q);
    r10 = 2 * (b * c + a * q);
    r11 = a * a - b * b + c * c - q * q;
    r12 = 2 * (c * q - a * b);
    wx = rotate_axis(r00, r01, r02, ax, ay, az);
    wy = rotate_axis(r10, r11, r12, ax, ay, az);
    return longint'(unsigned'(wx * wx)) + longint'(unsigned'(wy * wy));
  endfunction

  // Advance the recovery flags for one sample and return the new flag
  function automatic logic advance_recovery(logic armed, logic rreset, logic above);
    if (armed) begin
      if (!spike_over && !above) spike_over = 1'b1;
      if (!recov_model && spike_over) begin
        if (above) begin
          recov_model = 1'b1;
          spike_over = 1'b0;
        end
      end else if (recov_model && rreset) begin
        recov_model = 1'b0;
      end
    end
    return recov_model;
  endfunction

  function automatic sample_t mk_sample(int ax, int ay, int az, int qw, int qx,
                                        int qy, int qz, bit armed, bit rreset);
    sample_t s;
    s.data.accel_x = 16'(ax);
    s.data.accel_y = 16'(ay);
    s.data.accel_z = 16'(az);
    s.data.quat_w = 16'(qw);
    s.data.quat_x = 16'(qx);
    s.data.quat_y = 16'(qy);
    s.data.quat_z = 16'(qz);
    s.armed = armed;
    s.rreset = rreset;
    return s;
  endfunction

  function automatic int rand_q();
    return int'($urandom_range(2 * Q_ONE)) - Q_ONE;
  endfunction

  function automatic int rand_sym(int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  function automatic int rand_sign();
    return $urandom_range(1) ? 1 : -1;
  endfunction

  // Arbitrary sample: acceleration fields anywhere in their range, quaternion fields from -Q_ONE to Q_ONE
  function automatic sample_t noise_sample();
    return mk_sample(int'(16'($urandom)) - 32768 + 32768 * 0 + 0,
                     int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                     rand_q(), rand_q(), rand_q(), rand_q(),
                     $urandom_range(1), $urandom_range(1));
  endfunction

  // Sample aimed below, above or right at the threshold, with an attitude
  // that keeps the horizontal magnitude (yaw turns and half turns)
  function automatic sample_t impact_sample(int thr);
    int ax, ay, r, sg, pick, lvl;
    int qw, qx, qy, qz;
    lvl = $urandom_range(99);
    sg = rand_sign();
    pick = $urandom_range(4);
    qw = 0;
    qx = 0;
    qy = 0;
    qz = 0;
    case (pick)
      0: qw = Q_ONE;
      1: begin
        qw = Q_C45;
        qz = Q_C45;
      end
      2: qz = Q_ONE;
      3: qx = Q_ONE;
      default: qy = Q_ONE;
    endcase
    if (lvl < 45) begin
      r = $urandom_range(thr / 2);
      ax = rand_sym(r);
      ay = rand_sym(r);
    end else if (lvl < 85) begin
      ax = thr + 1 + $urandom_range(thr);
      if (ax > 32767) ax = 32767;
      ax = ax * rand_sign();
      ay = rand_sign() * int'($urandom_range(32767, 1));
    end else begin
      // exactly at the threshold, or one unit of squared magnitude over it
      qw = Q_ONE;
      qx = 0;
      qy = 0;
      qz = 0;
      ax = rand_sign() * thr;
      ay = $urandom_range(1) ? rand_sign() : 0;
    end
    return mk_sample(ax, ay, int'($signed(16'($urandom))), sg * qw, sg * qx,
                     sg * qy, sg * qz, $urandom_range(9) != 0,
                     $urandom_range(6) == 0);
  endfunction

  // Sender: present the next pending sample, with random gaps unless no_gaps is set
  always @(posedge clk_i) begin : sample_driver
    sample_t s;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_samples.size() != 0 && (no_gaps || $urandom_range(99) >= 18)) begin
        s = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= s.data;
        s_axis_tuser <= {s.rreset, s.armed};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls unless no_gaps is set, plus one long hold-off to back the block up
  always @(posedge clk_i) begin : result_sink
    int unsigned hold_left;
    bit hold_done;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      m_axis_tready <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      m_axis_tready <= no_gaps || $urandom_range(99) >= 18;
    end
  end

  // Monitor: predict on each sample transfer, check on each result transfer
  always @(posedge clk_i) begin : result_monitor
    longint unsigned mag;
    longint unsigned thr_sq;
    result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) thr_model = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        mag = horiz_mag_sq(hid_pkg::in_data_t'(s_axis_tdata));
        thr_sq = longint'(thr_model) * longint'(thr_model);
        want.in_recovery = advance_recovery(s_axis_tuser[0], s_axis_tuser[1],
                                            mag > thr_sq);
        want.mag_sq = (mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
        expected_results.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: in_recovery %0d, mag_sq %0d",
                 m_axis_tuser[0], m_axis_tdata);
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser[0] !== want.in_recovery) begin
            $error("in_recovery: expected %0d, actual %0d", want.in_recovery,
                   m_axis_tuser[0]);
            errors = errors + 1;
          end
          if (m_axis_tdata !== want.mag_sq) begin
            $error("horizontal_mag_sq: expected %0d, actual %0d", want.mag_sq,
                   m_axis_tdata);
            errors = errors + 1;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Wait until every sample is taken and every result is back
  task automatic wait_idle();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [hid_pkg::THR_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int thr_list[6];
    int cur_thr;
    thr_list[0] = 32767;
    thr_list[1] = 0;
    thr_list[2] = $urandom_range(32767);
    thr_list[3] = 1;
    thr_list[4] = $urandom_range(4000, 100);
    thr_list[5] = 2511;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset threshold, level attitude up to the field extremes
    pending_samples.push_back(mk_sample(0, 0, 0, Q_ONE, 0, 0, 0, 1, 0));
    // exactly at the threshold: no impact
    pending_samples.push_back(mk_sample(2511, 0, 0, Q_ONE, 0, 0, 0, 1, 0));
    // just over: impact, recovery set
    pending_samples.push_back(mk_sample(2512, 0, 0, Q_ONE, 0, 0, 0, 1, 0));
    // reset while the spike is still running
    pending_samples.push_back(mk_sample(2600, 0, 0, Q_ONE, 0, 0, 0, 1, 1));
    // spike still running, not in recovery: nothing changes
    pending_samples.push_back(mk_sample(0, -3000, 0, Q_ONE, 0, 0, 0, 1, 0));
    // drop back below: re-arm
    pending_samples.push_back(mk_sample(100, 0, 0, Q_ONE, 0, 0, 0, 1, 0));
    // not armed: state holds even on a spike
    pending_samples.push_back(mk_sample(5000, 0, 0, Q_ONE, 0, 0, 0, 0, 0));
    pending_samples.push_back(mk_sample(-5000, 0, 0, Q_ONE, 0, 0, 0, 1, 0));
    pending_samples.push_back(mk_sample(10, 0, 0, Q_ONE, 0, 0, 0, 1, 0));
    // reset flag while not armed: ignored
    pending_samples.push_back(mk_sample(10, 0, 0, Q_ONE, 0, 0, 0, 0, 1));
    pending_samples.push_back(mk_sample(10, 0, 0, Q_ONE, 0, 0, 0, 1, 1));
    // reset flag while not in recovery: no effect
    pending_samples.push_back(mk_sample(10, 0, 0, Q_ONE, 0, 0, 0, 1, 1));
    // field extremes, some with saturated output
    pending_samples.push_back(mk_sample(-32768, -32768, -32768, -Q_ONE, -Q_ONE,
                                        -Q_ONE, -Q_ONE, 0, 0));
    pending_samples.push_back(mk_sample(32767, 32767, 32767, Q_ONE, Q_ONE, Q_ONE,
                                        Q_ONE, 1, 0));
    pending_samples.push_back(mk_sample(32767, -32768, 32767, Q_ONE, -Q_ONE, Q_ONE,
                                        -Q_ONE, 1, 1));
    pending_samples.push_back(mk_sample(0, -32768, 32767, 0, Q_ONE, 0, 0, 1, 0));
    pending_samples.push_back(mk_sample(32767, 32767, 32767, 0, 0, 0, 0, 1, 1));
    pending_samples.push_back(mk_sample(32767, 0, -32768, Q_C45, 0, 0, Q_C45, 1, 0));
    pending_samples.push_back(mk_sample(-1, -1, -1, -1, -1, -1, -1, 1, 1));
    pending_samples.push_back(mk_sample(-32768, 32767, 0, 0, 0, -Q_ONE, 0, 1, 0));
    wait_idle();

    // Random phases, one threshold each; the third runs without gaps
    foreach (thr_list[p]) begin
      cur_thr = thr_list[p];
      write_threshold(cur_thr[hid_pkg::THR_W-1:0]);
      no_gaps = (p == 2);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if ($urandom_range(99) < 70) pending_samples.push_back(impact_sample(cur_thr));
        else pending_samples.push_back(noise_sample());
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
